// File: src/text_console_writer_defines.svh
// ----------------------------------------------------------------------------
// Text console writer: assertion macros
// Shared assertion forms. They expect signals named clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// Property checked at every clock edge outside of reset.
`define TCW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Consequence checked in the cycle after the condition, outside of reset.
`define TCW_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

// File: src/tcw_pkg.sv
// ----------------------------------------------------------------------------
// Text console writer package
// Field widths, character and register codes, and shared types.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLUMNS_DEFAULT = 80;
  localparam int ROWS_DEFAULT    = 25;

  localparam int CHAR_W    = 8;
  localparam int INDEX_W   = 11;
  localparam int WORD_W    = 16;
  localparam int COLOR_W   = 4;
  localparam int REG_IDX_W = 2;

  typedef enum logic {
    CMD_PUT  = 1'b0,
    CMD_READ = 1'b1
  } command_t;

  localparam logic [CHAR_W-1:0] CHAR_NUL     = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;

  localparam logic [REG_IDX_W-1:0] REG_FOREGROUND = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_BACKGROUND = 2'd1;

  localparam logic [COLOR_W-1:0] FOREGROUND_RESET = 4'hF;
  localparam logic [COLOR_W-1:0] BACKGROUND_RESET = 4'h0;

  // Request to the cursor unit: advance by one character or take a newline.
  typedef struct packed {
    logic step;
    logic newline;
  } cursor_op_t;

endpackage

// File: src/tcw_item_if.sv
// ----------------------------------------------------------------------------
// Text console writer: input item channel
// Valid/ready channel carrying one put-character or read-cell request.
// ----------------------------------------------------------------------------
interface tcw_item_if;
  logic                            valid;
  logic                            ready;
  tcw_pkg::command_t               command;
  logic [tcw_pkg::CHAR_W-1:0]      char_code;
  logic [tcw_pkg::INDEX_W-1:0]     cell_index;

  modport source (output valid, output command, output char_code, output cell_index,
                  input ready);
  modport sink (input valid, input command, input char_code, input cell_index,
                output ready);
endinterface

// File: src/tcw_result_if.sv
// ----------------------------------------------------------------------------
// Text console writer: result channel
// Valid/ready channel carrying the cursor position, a cell word and a flag.
// ----------------------------------------------------------------------------
interface tcw_result_if;
  logic                          valid;
  logic                          ready;
  logic [tcw_pkg::INDEX_W-1:0]   cursor_position;
  logic [tcw_pkg::WORD_W-1:0]    cell_word;
  logic                          scrolled;

  modport source (output valid, output cursor_position, output cell_word,
                  output scrolled, input ready);
  modport sink (input valid, input cursor_position, input cell_word,
                input scrolled, output ready);
endinterface

// File: src/tcw_cfg_if.sv
// ----------------------------------------------------------------------------
// Text console writer: configuration write channel
// Valid/ready channel carrying a register index and its write data.
// ----------------------------------------------------------------------------
interface tcw_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [tcw_pkg::REG_IDX_W-1:0]   reg_index;
  logic [tcw_pkg::COLOR_W-1:0]     write_data;

  modport source (output valid, output reg_index, output write_data, input ready);
  modport sink (input valid, input reg_index, input write_data, output ready);
endinterface

// File: src/tcw_ram.sv
// ----------------------------------------------------------------------------
// Text console writer: generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = tcw_pkg::WORD_W,
  parameter int DEPTH = tcw_pkg::COLUMNS_DEFAULT * tcw_pkg::ROWS_DEFAULT,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/tcw_cursor.sv
// ----------------------------------------------------------------------------
// Text console writer: cursor unit
// Holds row, column and linear position and reports when a step runs past
// the last row, which the sequencer answers with a scroll.
// ----------------------------------------------------------------------------
`include "text_console_writer_defines.svh"

module tcw_cursor #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
  parameter int ROWS    = tcw_pkg::ROWS_DEFAULT,
  localparam int ADDR_W = $clog2(COLUMNS * ROWS)
) (
  input  logic                clk,
  input  logic                rst,
  input  tcw_pkg::cursor_op_t op,
  output logic [ADDR_W-1:0]   pos,
  output logic [ADDR_W-1:0]   pos_next,
  output logic                overflow
);

  localparam int COL_W = $clog2(COLUMNS);
  localparam int ROW_W = $clog2(ROWS);

  logic [ROW_W-1:0] row, row_next;
  logic [COL_W-1:0] col, col_next;
  logic             line_end;

  always_comb begin
    line_end = op.newline || (col == COL_W'(COLUMNS - 1));
    overflow = op.step && line_end && (row == ROW_W'(ROWS - 1));
    row_next = row;
    col_next = col;
    pos_next = pos;
    if (op.step) begin
      if (overflow) begin
        row_next = ROW_W'(ROWS - 1);
        col_next = '0;
        pos_next = ADDR_W'((ROWS - 1) * COLUMNS);
      end else if (line_end) begin
        // Start of the next row, whether reached by newline or by wrapping.
        row_next = row + 1'b1;
        col_next = '0;
        pos_next = pos - ADDR_W'(col) + ADDR_W'(COLUMNS);
      end else begin
        col_next = col + 1'b1;
        pos_next = pos + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      col <= '0;
      pos <= '0;
    end else begin
      row <= row_next;
      col <= col_next;
      pos <= pos_next;
    end
  end

  `TCW_ASSERT(a_pos_consistent, int'(pos) == int'(row) * COLUMNS + int'(col), "cursor position disagrees with row and column")
  `TCW_ASSERT(a_col_range, int'(col) < COLUMNS && int'(row) < ROWS, "cursor outside the screen")
  `TCW_ASSERT(a_overflow_last_row, overflow |-> (row == ROW_W'(ROWS - 1)), "overflow away from the last row")

endmodule

// File: src/text_console_writer.sv
// ----------------------------------------------------------------------------
// Text console writer
// Put-character item: result registered at the next edge, a new item taken
// as the result is taken; a put that runs past the last row scrolls through
// ST_MOVE and ST_FILL. Read item: through ST_READ, bound by the registered
// read of the screen RAM. After reset a clearing pass writes all ROWS*COLUMNS
// cells with items held off; configuration writes are taken at all times.
// ----------------------------------------------------------------------------
`include "text_console_writer_defines.svh"

module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
  parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  tcw_item_if.sink     item,
  tcw_result_if.source result,
  tcw_cfg_if.sink      cfg
);

  localparam int CELLS      = COLUMNS * ROWS;
  localparam int MOVE_CELLS = (ROWS - 1) * COLUMNS;
  localparam int ADDR_W     = $clog2(CELLS);
  localparam int IW         = tcw_pkg::INDEX_W;
  localparam int WW         = tcw_pkg::WORD_W;
  localparam int CW         = tcw_pkg::COLOR_W;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MOVE,
    ST_FILL
  } state_t;

  state_t state;

  logic [CW-1:0]     fg, bg;
  logic [ADDR_W-1:0] sweep;
  logic [ADDR_W-1:0] sweep_ahead;
  logic [ADDR_W-1:0] wr_addr_d;
  logic              move_pend;
  logic              rd_ok;

  logic              res_valid;
  logic              res_set;
  logic [IW-1:0]     res_pos;
  logic [WW-1:0]     res_word;
  logic              res_scrolled;

  logic              accept;
  logic              is_put;
  logic              printable;
  tcw_pkg::cursor_op_t cur_op;
  logic [ADDR_W-1:0] cur_pos, cur_pos_next;
  logic              cur_overflow;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [WW-1:0]     ram_wdata, ram_rdata;

  // Configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fg <= tcw_pkg::FOREGROUND_RESET;
      bg <= tcw_pkg::BACKGROUND_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.reg_index)
        tcw_pkg::REG_FOREGROUND: fg <= cfg.write_data;
        tcw_pkg::REG_BACKGROUND: bg <= cfg.write_data;
        default: ;
      endcase
    end
  end

  // Item handshake and cursor request
  assign item.ready = (state == ST_IDLE) && (!res_valid || result.ready);
  assign accept     = item.valid && item.ready;
  assign is_put     = (item.command == tcw_pkg::CMD_PUT);
  assign printable  = (item.char_code != tcw_pkg::CHAR_NUL) &&
                      (item.char_code != tcw_pkg::CHAR_NEWLINE);

  always_comb begin
    cur_op.step    = accept && is_put && (item.char_code != tcw_pkg::CHAR_NUL);
    cur_op.newline = (item.char_code == tcw_pkg::CHAR_NEWLINE);
  end

  tcw_cursor #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_cursor (
    .clk      (clk),
    .rst      (rst),
    .op       (cur_op),
    .pos      (cur_pos),
    .pos_next (cur_pos_next),
    .overflow (cur_overflow)
  );

  // RAM port control. The scroll reads one row ahead of the cell it writes.
  assign sweep_ahead = sweep + ADDR_W'(COLUMNS);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = sweep;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = sweep_ahead;
    unique case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_IDLE: begin
        if (accept && is_put && printable) begin
          ram_we    = 1'b1;
          ram_waddr = cur_pos;
          ram_wdata = {bg, fg, item.char_code};
        end
        if (accept && !is_put) begin
          ram_re    = 1'b1;
          ram_raddr = ADDR_W'(item.cell_index);
        end
      end
      ST_READ: ;
      ST_MOVE: begin
        ram_re = 1'b1;
        if (move_pend) begin
          ram_we    = 1'b1;
          ram_waddr = wr_addr_d;
          ram_wdata = ram_rdata;
        end
      end
      ST_FILL: begin
        ram_we = 1'b1;
        if (move_pend) begin
          ram_waddr = wr_addr_d;
          ram_wdata = ram_rdata;
        end else begin
          ram_wdata = {bg, fg, tcw_pkg::CHAR_SPACE};
        end
      end
      default: ;
    endcase
  end

  tcw_ram #(
    .WIDTH (WW),
    .DEPTH (CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // A new result is loaded by a plain put, the end of a read or the end of a scroll.
  assign res_set = (accept && is_put && !cur_overflow) || (state == ST_READ) ||
                   (state == ST_FILL && !move_pend && sweep == ADDR_W'(CELLS - 1));

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      sweep     <= '0;
      move_pend <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (res_set) begin
        res_valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          if (sweep == ADDR_W'(CELLS - 1)) begin
            sweep <= '0;
            state <= ST_IDLE;
          end else begin
            sweep <= sweep + 1'b1;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            if (!is_put) begin
              rd_ok <= int'(item.cell_index) < CELLS;
              state <= ST_READ;
            end else if (cur_overflow) begin
              sweep     <= '0;
              move_pend <= 1'b0;
              state     <= ST_MOVE;
            end else begin
              res_pos      <= IW'(cur_pos_next);
              res_word     <= '0;
              res_scrolled <= 1'b0;
            end
          end
        end
        ST_READ: begin
          res_pos      <= IW'(cur_pos);
          res_word     <= rd_ok ? ram_rdata : '0;
          res_scrolled <= 1'b0;
          state        <= ST_IDLE;
        end
        ST_MOVE: begin
          move_pend <= 1'b1;
          wr_addr_d <= sweep;
          sweep     <= sweep + 1'b1;
          if (sweep == ADDR_W'(MOVE_CELLS - 1)) begin
            state <= ST_FILL;
          end
        end
        ST_FILL: begin
          // The last moved cell takes the write port first; the fill waits.
          if (move_pend) begin
            move_pend <= 1'b0;
          end else if (sweep == ADDR_W'(CELLS - 1)) begin
            sweep        <= '0;
            res_pos      <= IW'(cur_pos);
            res_word     <= '0;
            res_scrolled <= 1'b1;
            state        <= ST_IDLE;
          end else begin
            sweep <= sweep + 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign result.valid           = res_valid;
  assign result.cursor_position = res_pos;
  assign result.cell_word       = res_word;
  assign result.scrolled        = res_scrolled;

  `TCW_ASSERT(a_busy_not_ready, (state == ST_CLEAR || state == ST_MOVE || state == ST_FILL) |-> !item.ready, "item taken during a sweep")
  `TCW_ASSERT(a_pend_in_scroll, move_pend |-> (state == ST_MOVE || state == ST_FILL), "pending move outside a scroll")
  `TCW_ASSERT(a_scroll_pos, (res_valid && res_scrolled) |-> (res_pos == IW'(MOVE_CELLS)), "scroll result not at last row start")
  `TCW_ASSERT_NEXT(a_scroll_entry, accept && is_put && cur_overflow, state == ST_MOVE && !res_valid, "overflow did not start a scroll")

endmodule

// File: bench/text_console_writer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Text console writer testbench
// Drives put-character and read-cell requests and color register writes into
// the console. A scoreboard keeps its own screen, cursor and colors, and
// checks each result transfer in order against the value it predicts.
// ----------------------------------------------------------------------------
module text_console_writer_tb;

  localparam int COLUMNS       = tcw_pkg::COLUMNS_DEFAULT;
  localparam int ROWS          = tcw_pkg::ROWS_DEFAULT;
  localparam int CELLS         = COLUMNS * ROWS;
  localparam int CHAR_W        = tcw_pkg::CHAR_W;
  localparam int INDEX_W       = tcw_pkg::INDEX_W;
  localparam int WORD_W        = tcw_pkg::WORD_W;
  localparam int COLOR_W       = tcw_pkg::COLOR_W;
  localparam int REG_IDX_W     = tcw_pkg::REG_IDX_W;
  localparam int PERIOD        = 10;
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 275;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 12000;

  // Register slots that decode to nothing.
  localparam logic [REG_IDX_W-1:0] REG_SPARE_LOW  = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_HIGH = 2'd3;

  typedef struct packed {
    logic [INDEX_W-1:0] cursor_position;
    logic [WORD_W-1:0]  cell_word;
    logic               scrolled;
  } console_result_t;

  class console_scoreboard;
    int unsigned        row;
    int unsigned        column;
    logic [WORD_W-1:0]  screen [CELLS];
    logic [COLOR_W-1:0] foreground;
    logic [COLOR_W-1:0] background;
    console_result_t    awaited [$];
    int                 errors;

    function new();
      row        = 0;
      column     = 0;
      foreground = tcw_pkg::FOREGROUND_RESET;
      background = tcw_pkg::BACKGROUND_RESET;
      errors     = 0;
      foreach (screen[i]) screen[i] = '0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void take_register(logic [REG_IDX_W-1:0] index, logic [COLOR_W-1:0] data);
      if (index == tcw_pkg::REG_FOREGROUND) foreground = data;
      else if (index == tcw_pkg::REG_BACKGROUND) background = data;
    endfunction

    // Applies one accepted request to the screen copy and queues its result.
    function void log_item(tcw_pkg::command_t command, logic [CHAR_W-1:0] ch,
                           logic [INDEX_W-1:0] index);
      console_result_t want;
      want = '0;
      if (command == tcw_pkg::CMD_READ) begin
        if (index < CELLS) want.cell_word = screen[index];
      end else if (ch != tcw_pkg::CHAR_NUL) begin
        if (ch == tcw_pkg::CHAR_NEWLINE) begin
          column = 0;
          row++;
        end else begin
          screen[row * COLUMNS + column] = {background, foreground, ch};
          column++;
        end
        if (column >= COLUMNS) begin
          column = 0;
          row++;
        end
        if (row >= ROWS) begin
          for (int i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
          for (int i = CELLS - COLUMNS; i < CELLS; i++)
            screen[i] = {background, foreground, tcw_pkg::CHAR_SPACE};
          column = 0;
          row = ROWS - 1;
          want.scrolled = 1'b1;
        end
      end
      want.cursor_position = INDEX_W'(row * COLUMNS + column);
      awaited.push_back(want);
    endfunction

    function void flag(string what);
      errors++;
      $display("%0t: %s", $time, what);
    endfunction

    function void check_result(logic [INDEX_W-1:0] position, logic [WORD_W-1:0] word,
                               logic scrolled);
      console_result_t want;
      if (awaited.size() == 0) begin
        flag($sformatf("result with nothing expected: position %0d word %h scrolled %b",
                       position, word, scrolled));
        return;
      end
      want = awaited.pop_front();
      if (position !== want.cursor_position)
        flag($sformatf("cursor_position expected %0d, got %0d",
                       want.cursor_position, position));
      if (word !== want.cell_word)
        flag($sformatf("cell_word expected %h, got %h", want.cell_word, word));
      if (scrolled !== want.scrolled)
        flag($sformatf("scrolled expected %b, got %b", want.scrolled, scrolled));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic steady = 1'b0;
  int   items_sent = 0;
  int   quiet_cycles = 0;

  console_scoreboard board = new();

  tcw_item_if   item ();
  tcw_result_if result ();
  tcw_cfg_if    cfg ();

  text_console_writer #(
    .COLUMNS(COLUMNS),
    .ROWS(ROWS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .item(item),
    .result(result),
    .cfg(cfg)
  );

  always #(PERIOD / 2) clk = ~clk;

  // The receiver stalls now and then, never during the steady stretch.
  always @(negedge clk) begin
    result.ready <= steady || ($urandom_range(99) >= 6);
  end

  always @(posedge clk) begin
    if (!rst && result.valid && result.ready)
      board.check_result(result.cursor_position, result.cell_word, result.scrolled);
  end

  always @(posedge clk) begin
    if ((item.valid && item.ready) || (result.valid && result.ready) ||
        (cfg.valid && cfg.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("text_console_writer_tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  // Valid stays high so the next request can follow without a gap.
  task automatic send_item(tcw_pkg::command_t command, logic [CHAR_W-1:0] ch,
                           logic [INDEX_W-1:0] index);
    while (!steady && $urandom_range(99) < 6) begin
      item.valid <= 1'b0;
      @(negedge clk);
    end
    item.valid      <= 1'b1;
    item.command    <= command;
    item.char_code  <= ch;
    item.cell_index <= index;
    @(posedge clk);
    while (!item.ready) @(posedge clk);
    board.log_item(command, ch, index);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_register(logic [REG_IDX_W-1:0] index, logic [COLOR_W-1:0] data);
    cfg.valid      <= 1'b1;
    cfg.reg_index  <= index;
    cfg.write_data <= data;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    board.take_register(index, data);
    @(negedge clk);
  endtask

  task automatic hold_until_drained();
    item.valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    logic [COLOR_W-1:0] phase_fg [PHASES];
    logic [COLOR_W-1:0] phase_bg [PHASES];
    logic [COLOR_W-1:0] fg;
    logic [COLOR_W-1:0] bg;
    logic [CHAR_W-1:0]  ch;
    logic [INDEX_W-1:0] index;
    int                 burst;
    int                 phase_end;
    bit                 paused;

    phase_fg = '{4'h0, 4'hF, 4'h0, 4'h0, 4'h0, 4'hF};
    phase_bg = '{4'hF, 4'hF, 4'h0, 4'h0, 4'h0, 4'h0};

    item.valid      = 1'b0;
    item.command    = tcw_pkg::CMD_PUT;
    item.char_code  = tcw_pkg::CHAR_NUL;
    item.cell_index = '0;
    cfg.valid       = 1'b0;
    cfg.reg_index   = tcw_pkg::REG_FOREGROUND;
    cfg.write_data  = '0;

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Writes to undecoded slots must leave the colors at their reset values.
    write_register(REG_SPARE_LOW, 4'h0);
    write_register(REG_SPARE_HIGH, 4'hF);
    cfg.valid <= 1'b0;

    // Directed: reset contents, read range ends, NUL, extreme bytes, newline.
    send_item(tcw_pkg::CMD_READ, tcw_pkg::CHAR_NUL, '0);
    send_item(tcw_pkg::CMD_READ, tcw_pkg::CHAR_NUL, INDEX_W'(CELLS - 1));
    send_item(tcw_pkg::CMD_READ, tcw_pkg::CHAR_NUL, INDEX_W'(CELLS));
    send_item(tcw_pkg::CMD_READ, 8'hFF, '1);
    send_item(tcw_pkg::CMD_PUT, tcw_pkg::CHAR_NUL, '1);
    send_item(tcw_pkg::CMD_PUT, 8'h41, '0);
    send_item(tcw_pkg::CMD_PUT, 8'hFF, '1);
    send_item(tcw_pkg::CMD_PUT, 8'h01, '0);
    send_item(tcw_pkg::CMD_PUT, 8'h80, '0);
    send_item(tcw_pkg::CMD_PUT, tcw_pkg::CHAR_SPACE, '0);
    send_item(tcw_pkg::CMD_PUT, tcw_pkg::CHAR_NEWLINE, '0);
    send_item(tcw_pkg::CMD_PUT, 8'h7F, '0);
    send_item(tcw_pkg::CMD_PUT, tcw_pkg::CHAR_NUL, '0);
    send_item(tcw_pkg::CMD_PUT, tcw_pkg::CHAR_NEWLINE, '1);
    send_item(tcw_pkg::CMD_READ, tcw_pkg::CHAR_NUL, 11'd0);
    send_item(tcw_pkg::CMD_READ, tcw_pkg::CHAR_NUL, 11'd1);
    send_item(tcw_pkg::CMD_READ, tcw_pkg::CHAR_NUL, 11'd2);
    send_item(tcw_pkg::CMD_READ, tcw_pkg::CHAR_NUL, 11'd3);
    send_item(tcw_pkg::CMD_READ, tcw_pkg::CHAR_NUL, 11'd4);
    send_item(tcw_pkg::CMD_READ, tcw_pkg::CHAR_NUL, INDEX_W'(COLUMNS));
    send_item(tcw_pkg::CMD_READ, tcw_pkg::CHAR_NUL, INDEX_W'(COLUMNS + 1));
    send_item(tcw_pkg::CMD_READ, tcw_pkg::CHAR_NUL, INDEX_W'(2 * COLUMNS));

    for (int p = 0; p < PHASES; p++) begin
      hold_until_drained();
      fg = phase_fg[p];
      bg = phase_bg[p];
      if (p == 3 || p == 4) begin
        fg = COLOR_W'($urandom_range(15));
        bg = COLOR_W'($urandom_range(15));
      end
      write_register(tcw_pkg::REG_FOREGROUND, fg);
      write_register(tcw_pkg::REG_BACKGROUND, bg);
      cfg.valid <= 1'b0;
      steady = (p == 2);

      phase_end = items_sent + PHASE_ITEMS;
      paused = 1'b0;
      while (items_sent < phase_end) begin
        // Once per phase the sender waits until the console has caught up.
        if (!paused && items_sent >= phase_end - PHASE_ITEMS / 2) begin
          hold_until_drained();
          paused = 1'b1;
        end
        if ($urandom_range(99) < 30) begin
          burst = $urandom_range(6, 1);
          repeat (burst) begin
            if ($urandom_range(19) == 0) index = INDEX_W'($urandom_range(2047, CELLS));
            else index = INDEX_W'($urandom_range(CELLS - 1));
            send_item(tcw_pkg::CMD_READ, CHAR_W'($urandom), index);
          end
        end else begin
          // A line of text; some are long enough to wrap past the line end.
          burst = ($urandom_range(4) == 0) ? $urandom_range(170, 70) : $urandom_range(20);
          if (burst > phase_end - items_sent) burst = phase_end - items_sent;
          repeat (burst) begin
            ch = ($urandom_range(99) < 3) ? tcw_pkg::CHAR_NUL : CHAR_W'($urandom);
            send_item(tcw_pkg::CMD_PUT, ch, INDEX_W'($urandom));
          end
          if ($urandom_range(9) < 7)
            send_item(tcw_pkg::CMD_PUT, tcw_pkg::CHAR_NEWLINE, INDEX_W'($urandom));
        end
      end
    end

    steady = 1'b0;
    hold_until_drained();
    if (board.errors == 0 && board.pending() == 0) begin
      $display("text_console_writer_tb: done, clean");
    end else begin
      $display("text_console_writer_tb: done, errors");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+src
src/tcw_pkg.sv
src/tcw_item_if.sv
src/tcw_result_if.sv
src/tcw_cfg_if.sv
src/tcw_ram.sv
src/tcw_cursor.sv
src/text_console_writer.sv
bench/text_console_writer_tb.sv
